/* hdl/rmst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types and constants of the range-minimum segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

  localparam int DATA_W     = 60;
  localparam int POS_W      = 11;
  localparam int LEAVES_DEF = 1024;

  localparam logic [DATA_W-1:0] SENTINEL = 60'd1000000000000000000;

  typedef enum logic {
    ACT_LOWER = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_LEAF,
    ST_UPD_PATH,
    ST_QRY_WALK,
    ST_QRY_DONE
  } state_e;

  function automatic logic [DATA_W-1:0] min_val(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage
`default_nettype wire

/* hdl/range_min_segment_tree_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// range_min_segment_tree_top
// Bottom-up segment tree for point lowering and range-minimum queries,
// with the node minima held in one synchronous RAM of 2*LEAVES entries.
//
//   channel  | handshake                     | beat
//   ---------+-------------------------------+----------------------------------
//   command  | start, busy (taken: start&!busy) | action, position, range_end, value
//   result   | result_valid_o (one cycle)    | minimum
//
// After reset a clearing pass writes the sentinel into every node, one node
// per cycle; busy stays high meanwhile.
// Update: the leaf, then each ancestor up to the root, one tree level per cycle,
// limited by the single write port walking the leaf-to-root path.
// Query: busy while the bounds walk up the tree; each RAM read port fetches its
// boundary node when its bound is odd. Result strobe follows the last busy cycle.
// Empty queries answer the next cycle; ignored updates never raise busy.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module range_min_segment_tree_top #(
  parameter int LEAVES = rmst_pkg::LEAVES_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  output logic                        busy,
  input  wire                         action_i,
  input  wire  [rmst_pkg::POS_W-1:0]  position_i,
  input  wire  [rmst_pkg::POS_W-1:0]  range_end_i,
  input  wire  [rmst_pkg::DATA_W-1:0] value_i,
  output logic                        result_valid_o,
  output logic [rmst_pkg::DATA_W-1:0] minimum_o
);
  import rmst_pkg::*;

  localparam int NODES = 2 * LEAVES;
  localparam int NW    = $clog2(NODES);
  localparam int AW    = NW + 1;
  localparam int EW    = ((AW > POS_W) ? AW : POS_W) + 1;

  state_e state_q, state_d;

  logic [NW-1:0]     clr_q, clr_d;
  logic [AW-1:0]     a_q, a_d, b_q, b_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] cur_q, cur_d;
  logic [DATA_W-1:0] left_q, left_d, right_q, right_d;
  logic              pa_q, pa_d, pb_q, pb_d;
  logic              res_valid_q, res_valid_d;
  logic [DATA_W-1:0] res_q, res_d;

  logic [DATA_W-1:0] tree_mem [NODES];
  logic [DATA_W-1:0] rdata_a_q, rdata_b_q;
  logic              we, ren_a, ren_b;
  logic [NW-1:0]     waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] wdata;

  logic              accept, is_query, q_empty, upd_ok, walk_go, path_top;
  logic [EW-1:0]     pos_e, end_e, lo_e, hi_e, leaf_e, qa_e, qb_e;
  logic [NW-1:0]     parent_n;
  logic [AW-1:0]     bm1;
  logic [DATA_W-1:0] new_leaf, new_parent;

  assign accept   = start && (state_q == ST_IDLE);
  assign is_query = (action_e'(action_i) == ACT_QUERY);
  assign pos_e    = EW'(position_i);
  assign end_e    = EW'(range_end_i);
  assign lo_e     = (pos_e == '0) ? EW'(1) : pos_e;
  assign hi_e     = (end_e > EW'(LEAVES + 1)) ? EW'(LEAVES + 1) : end_e;
  assign q_empty  = (hi_e <= lo_e);
  assign upd_ok   = (pos_e != '0) && (pos_e <= EW'(LEAVES));
  assign leaf_e   = pos_e + EW'(LEAVES - 1);
  assign qa_e     = lo_e + EW'(LEAVES - 1);
  assign qb_e     = hi_e + EW'(LEAVES - 1);
  assign walk_go  = (b_q > a_q);
  assign bm1      = b_q - AW'(1);
  assign parent_n = a_q[NW-1:0] >> 1;
  assign path_top = (parent_n == NW'(1));
  assign new_leaf   = min_val(rdata_a_q, val_q);
  assign new_parent = min_val(cur_q, rdata_b_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == NW'(NODES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (is_query) begin
            if (!q_empty) state_d = ST_QRY_WALK;
          end else if (upd_ok) begin
            state_d = ST_UPD_LEAF;
          end
        end
      end
      ST_UPD_LEAF: state_d = ST_UPD_PATH;
      ST_UPD_PATH: begin
        if (path_top) state_d = ST_IDLE;
      end
      ST_QRY_WALK: begin
        if (!walk_go) state_d = ST_QRY_DONE;
      end
      ST_QRY_DONE: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_d       = clr_q;
    a_d         = a_q;
    b_d         = b_q;
    val_d       = val_q;
    cur_d       = cur_q;
    left_d      = left_q;
    right_d     = right_q;
    pa_d        = 1'b0;
    pb_d        = 1'b0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = a_q[NW-1:0];
    wdata       = new_leaf;
    ren_a       = 1'b0;
    ren_b       = 1'b0;
    raddr_a     = a_q[NW-1:0];
    raddr_b     = bm1[NW-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = SENTINEL;
        clr_d = clr_q + NW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          if (is_query) begin
            if (q_empty) begin
              res_valid_d = 1'b1;
              res_d       = SENTINEL;
            end else begin
              a_d     = AW'(qa_e);
              b_d     = AW'(qb_e);
              left_d  = SENTINEL;
              right_d = SENTINEL;
            end
          end else if (upd_ok) begin
            a_d     = AW'(leaf_e);
            val_d   = value_i;
            ren_a   = 1'b1;
            ren_b   = 1'b1;
            raddr_a = NW'(leaf_e);
            raddr_b = NW'(leaf_e) ^ NW'(1);
          end
        end
      end
      ST_UPD_LEAF: begin
        we    = 1'b1;
        wdata = new_leaf;
        cur_d = new_leaf;
      end
      ST_UPD_PATH: begin
        we    = 1'b1;
        waddr = parent_n;
        wdata = new_parent;
        cur_d = new_parent;
        a_d   = AW'(parent_n);
        if (!path_top) begin
          ren_b   = 1'b1;
          raddr_b = parent_n ^ NW'(1);
        end
      end
      ST_QRY_WALK: begin
        if (pa_q) left_d  = min_val(left_q, rdata_a_q);
        if (pb_q) right_d = min_val(right_q, rdata_b_q);
        if (walk_go) begin
          ren_a = a_q[0];
          ren_b = b_q[0];
          pa_d  = a_q[0];
          pb_d  = b_q[0];
          a_d   = (a_q + AW'(a_q[0])) >> 1;
          b_d   = b_q >> 1;
        end
      end
      ST_QRY_DONE: begin
        res_valid_d = 1'b1;
        res_d       = min_val(left_q, right_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) tree_mem[waddr] <= wdata;
    if (ren_a) rdata_a_q <= tree_mem[raddr_a];
    if (ren_b) rdata_b_q <= tree_mem[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pa_q        <= 1'b0;
      pb_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pa_q        <= pa_d;
      pb_q        <= pb_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    val_q   <= val_d;
    cur_q   <= cur_d;
    left_q  <= left_d;
    right_q <= right_d;
    res_q   <= res_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign minimum_o      = res_q;

endmodule
`default_nettype wire

/* hdl/rmst_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmst_checker
// Port-level checks of the range-minimum segment tree, bound to the top.
// ----------------------------------------------------------------------------
module rmst_checker (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         start,
  input wire                         busy,
  input wire                         action_i,
  input wire  [rmst_pkg::POS_W-1:0]  position_i,
  input wire  [rmst_pkg::POS_W-1:0]  range_end_i,
  input wire                         result_valid_o,
  input wire  [rmst_pkg::DATA_W-1:0] minimum_o
);
  import rmst_pkg::*;

  logic take_cmd, take_query, take_lower;

  assign take_cmd   = start && !busy;
  assign take_query = take_cmd && (action_e'(action_i) == ACT_QUERY);
  assign take_lower = take_cmd && (action_e'(action_i) == ACT_LOWER);

  // reported minima never exceed the sentinel
  a_min_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (minimum_o <= SENTINEL))
    else $error("minimum above sentinel");

  // empty range answers the sentinel on the next beat
  a_empty_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_query && (range_end_i <= position_i))
      |=> (result_valid_o && (minimum_o == SENTINEL)))
    else $error("empty query not answered with sentinel");

  // a lowering command never produces a beat right behind it
  a_lower_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_lower |=> !result_valid_o)
    else $error("result after update");

  // a non-empty query keeps the block busy for its walk
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_query && (position_i != '0) && (range_end_i > position_i)
      && (position_i <= POS_W'(LEAVES_DEF)))
      |=> (busy && !result_valid_o))
    else $error("query walk not busy");

endmodule

bind range_min_segment_tree_top rmst_checker u_rmst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .action_i       (action_i),
  .position_i     (position_i),
  .range_end_i    (range_end_i),
  .result_valid_o (result_valid_o),
  .minimum_o      (minimum_o)
);
`default_nettype wire

/* tb/sv/range_min_segment_tree_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_min_segment_tree_top_tb
// Self-checking bench for the range-minimum segment tree. A scoreboard keeps
// its own copy of the tree, mirrors every accepted lowering and predicts the
// minimum of every accepted query. Directed corner beats come first, then
// random beats in three phases of sender gaps.
// ----------------------------------------------------------------------------

typedef struct {
  rmst_pkg::action_e               act;
  logic [rmst_pkg::POS_W-1:0]      pos;
  logic [rmst_pkg::POS_W-1:0]      rend;
  logic [rmst_pkg::DATA_W-1:0]     val;
} tree_cmd_t;

class min_tree_scoreboard;
  localparam int NODES = 2 * rmst_pkg::LEAVES_DEF;

  logic [rmst_pkg::DATA_W-1:0] node_min [NODES];
  logic [rmst_pkg::DATA_W-1:0] pending_minima [$];
  int unsigned                 fail_count;

  function new();
    foreach (node_min[k]) node_min[k] = rmst_pkg::SENTINEL;
    fail_count = 0;
  endfunction

  function logic [rmst_pkg::DATA_W-1:0] lesser(logic [rmst_pkg::DATA_W-1:0] a,
                                               logic [rmst_pkg::DATA_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function logic [rmst_pkg::DATA_W-1:0] node_at(int k);
    return (k < NODES) ? node_min[k] : rmst_pkg::SENTINEL;
  endfunction

  function void lower_leaf(int pos, logic [rmst_pkg::DATA_W-1:0] val);
    int k;
    if (pos < 1 || pos > rmst_pkg::LEAVES_DEF) return;
    k = pos + rmst_pkg::LEAVES_DEF - 1;
    node_min[k] = lesser(node_min[k], val);
    while (k > 1) begin
      k = k >> 1;
      node_min[k] = lesser(node_at(2 * k), node_at(2 * k + 1));
    end
  endfunction

  function logic [rmst_pkg::DATA_W-1:0] span_min(int lo, int hi);
    logic [rmst_pkg::DATA_W-1:0] left_acc;
    logic [rmst_pkg::DATA_W-1:0] right_acc;
    int a;
    int b;
    left_acc  = rmst_pkg::SENTINEL;
    right_acc = rmst_pkg::SENTINEL;
    if (lo < 1) lo = 1;
    if (hi > rmst_pkg::LEAVES_DEF + 1) hi = rmst_pkg::LEAVES_DEF + 1;
    if (hi <= lo) return rmst_pkg::SENTINEL;
    a = lo + rmst_pkg::LEAVES_DEF - 1;
    b = hi + rmst_pkg::LEAVES_DEF - 1;
    while (b > a) begin
      if (a[0]) begin
        left_acc = lesser(left_acc, node_at(a));
        a++;
      end
      if (b[0]) begin
        b--;
        right_acc = lesser(right_acc, node_at(b));
      end
      a = a >> 1;
      b = b >> 1;
    end
    return lesser(left_acc, right_acc);
  endfunction

  function void note_command(tree_cmd_t cmd);
    if (cmd.act == rmst_pkg::ACT_LOWER)
      lower_leaf(int'(cmd.pos), cmd.val);
    else
      pending_minima = {pending_minima, span_min(int'(cmd.pos), int'(cmd.rend))};
  endfunction

  function void check_minimum(logic [rmst_pkg::DATA_W-1:0] actual);
    logic [rmst_pkg::DATA_W-1:0] expected;
    if (pending_minima.size() == 0) begin
      $display("%0t ns: unexpected result, expected none, actual %0d", $time, actual);
      fail_count++;
      return;
    end
    expected = pending_minima.pop_front();
    if (actual !== expected) begin
      $display("%0t ns: minimum mismatch, expected %0d, actual %0d",
               $time, expected, actual);
      fail_count++;
    end
  endfunction
endclass

module range_min_segment_tree_top_tb;

  localparam int LEAVES     = rmst_pkg::LEAVES_DEF;
  localparam int POS_W      = rmst_pkg::POS_W;
  localparam int DATA_W     = rmst_pkg::DATA_W;
  localparam int CYCLE_CAP  = 250000;
  localparam int RAND_BEATS = 1300;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic                        action_i;
  logic [rmst_pkg::POS_W-1:0]  position_i;
  logic [rmst_pkg::POS_W-1:0]  range_end_i;
  logic [rmst_pkg::DATA_W-1:0] value_i;
  logic                        result_valid_o;
  logic [rmst_pkg::DATA_W-1:0] minimum_o;

  min_tree_scoreboard sb;
  int unsigned        cycle_count;
  int unsigned        gap_pct;

  range_min_segment_tree_top #(.LEAVES(LEAVES)) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .position_i     (position_i),
    .range_end_i    (range_end_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .minimum_o      (minimum_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_minimum(minimum_o);
  end

  task automatic issue(tree_cmd_t cmd);
    @(negedge clk_i);
    start       <= 1'b1;
    action_i    <= cmd.act;
    position_i  <= cmd.pos;
    range_end_i <= cmd.rend;
    value_i     <= cmd.val;
    do @(posedge clk_i); while (busy);
    sb.note_command(cmd);
  endtask

  task automatic hold_off(int unsigned n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic send(rmst_pkg::action_e act, int pos, int rend, logic [63:0] val);
    tree_cmd_t cmd;
    cmd.act  = act;
    cmd.pos  = pos[rmst_pkg::POS_W-1:0];
    cmd.rend = rend[rmst_pkg::POS_W-1:0];
    cmd.val  = val[rmst_pkg::DATA_W-1:0];
    issue(cmd);
  endtask

  function automatic logic [rmst_pkg::DATA_W-1:0] random_value();
    logic [63:0]  r;
    int unsigned  pick;
    r    = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 10) return r[rmst_pkg::DATA_W-1:0];
    if (pick < 30) return DATA_W'($urandom_range(0, 1000));
    return r[rmst_pkg::DATA_W-1:0] % rmst_pkg::SENTINEL;
  endfunction

  function automatic tree_cmd_t random_command();
    tree_cmd_t   cmd;
    int unsigned pick;
    int          lo;
    int          hi;
    cmd.val  = random_value();
    cmd.rend = POS_W'($urandom_range(0, 2047));
    pick     = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 55) begin
      cmd.act = rmst_pkg::ACT_LOWER;
      cmd.pos = (pick < 90) ? POS_W'($urandom_range(1, LEAVES))
                            : POS_W'($urandom_range(0, 2047));
    end else begin
      cmd.act = rmst_pkg::ACT_QUERY;
      lo = $urandom_range(1, LEAVES);
      if (pick < 40)      hi = lo + $urandom_range(0, 64);
      else if (pick < 70) hi = $urandom_range(lo, LEAVES + 1);
      else if (pick < 90) begin
        lo = $urandom_range(0, 2047);
        hi = $urandom_range(0, 2047);
      end else            hi = $urandom_range(0, lo);
      cmd.pos  = lo[rmst_pkg::POS_W-1:0];
      cmd.rend = hi[rmst_pkg::POS_W-1:0];
    end
    return cmd;
  endfunction

  initial begin
    sb          = new();
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    action_i    = 1'b0;
    position_i  = '0;
    range_end_i = '0;
    value_i     = '0;
    cycle_count = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners
    send(rmst_pkg::ACT_QUERY, 1, LEAVES + 1, 64'd0);
    send(rmst_pkg::ACT_LOWER, 1, 2047, 64'd0);
    send(rmst_pkg::ACT_LOWER, LEAVES, 0, 64'd999999999999999999);
    send(rmst_pkg::ACT_LOWER, 0, 5, 64'd5);
    send(rmst_pkg::ACT_LOWER, LEAVES + 1, 5, 64'd3);
    send(rmst_pkg::ACT_LOWER, 2047, 2047, 64'd1);
    send(rmst_pkg::ACT_LOWER, 512, 100, 64'h0FFF_FFFF_FFFF_FFFF);
    send(rmst_pkg::ACT_QUERY, 512, 513, 64'd0);
    send(rmst_pkg::ACT_LOWER, 512, 1, 64'd7);
    send(rmst_pkg::ACT_LOWER, 512, 1, 64'd100);
    send(rmst_pkg::ACT_QUERY, 1, LEAVES + 1, 64'h0FFF_FFFF_FFFF_FFFF);
    send(rmst_pkg::ACT_QUERY, 0, 2047, 64'd0);
    send(rmst_pkg::ACT_QUERY, 2, LEAVES, 64'd0);
    send(rmst_pkg::ACT_QUERY, 513, LEAVES, 64'd0);
    send(rmst_pkg::ACT_QUERY, LEAVES, LEAVES + 1, 64'd0);
    send(rmst_pkg::ACT_QUERY, 513, 513, 64'd0);
    send(rmst_pkg::ACT_QUERY, 600, 3, 64'd0);
    send(rmst_pkg::ACT_QUERY, 0, 0, 64'd0);
    send(rmst_pkg::ACT_QUERY, 2047, 2047, 64'd0);
    send(rmst_pkg::ACT_QUERY, 0, 1, 64'd0);
    send(rmst_pkg::ACT_QUERY, 1, 2, 64'd0);

    // random beats in three gap phases
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 19 : (ph == 1) ? 57 : 0;
      for (int i = 0; i < RAND_BEATS / 3; i++) begin
        issue(random_command());
        while ($urandom_range(0, 99) < gap_pct) hold_off(1);
      end
    end
    @(negedge clk_i);
    start <= 1'b0;

    while (sb.pending_minima.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);

    if (sb.fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
hdl/rmst_pkg.sv
hdl/range_min_segment_tree_top.sv
hdl/rmst_checker.sv
tb/sv/range_min_segment_tree_top_tb.sv
